FILE: rtl/bmpdec_pkg.sv
package bmpdec_pkg;

	// Largest image side accepted by default
	localparam int MAX_DIM_DEF = 1024;

	// Header layout: byte offsets of the captured fields
	localparam int HDR_OFS_MAGIC  = 0;
	localparam int HDR_OFS_DATA   = 10;
	localparam int HDR_OFS_WIDTH  = 18;
	localparam int HDR_OFS_HEIGHT = 22;
	localparam int HDR_OFS_BPP    = 28;
	localparam int HDR_OFS_COMP   = 30;
	localparam logic [5:0]  HDR_LAST_POS = 6'd53;
	localparam logic [31:0] HDR_SIZE     = 32'd54;

	// Values the header must carry
	localparam logic [15:0] BMP_MAGIC = 16'h4D42;
	localparam logic [15:0] BMP_BPP   = 16'd24;
	localparam logic [31:0] BMP_COMP_NONE = 32'd0;

	// Chroma key register reset values and alpha codes
	localparam logic [7:0] KEY_MIN_RB_RST = 8'd248;
	localparam logic [7:0] KEY_MAX_G_RST  = 8'd8;
	localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR    = 8'h00;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_KEY_MIN_RB = 1'b0,
		CFG_KEY_MAX_G  = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_SKIP   = 3'd1,
		PH_PIXEL  = 3'd2,
		PH_PAD    = 3'd3,
		PH_DONE   = 3'd4,
		PH_ERROR  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PIXEL  = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_MAGIC  = 3'd1,
		ERR_FORMAT = 3'd2,
		ERR_DIMS   = 3'd3,
		ERR_OFFSET = 3'd4,
		ERR_TRUNC  = 3'd5
	} err_t;

	// One input request as held in the input register
	typedef struct packed {
		logic [7:0] file_byte;
		logic       start_of_file;
		logic       end_of_file;
	} item_t;

	// Header byte capture strobe from the parser
	typedef struct packed {
		logic       en;
		logic [5:0] pos;
		logic [7:0] data;
	} cap_t;

	// Header check outcome
	typedef struct packed {
		err_t err;
		logic bottom_up;
	} hdr_chk_t;

	// One result request
	typedef struct packed {
		kind_t       kind;
		err_t        err;
		logic [15:0] rgb565;
		logic [7:0]  alpha;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic [10:0] image_width;
		logic [10:0] image_height;
		logic        last_pixel;
	} res_t;

endpackage

FILE: rtl/bmpdec_if.sv
// Byte stream channel
interface bmpdec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       start_of_file;
	logic       end_of_file;

	modport source(output valid, file_byte, start_of_file, end_of_file, input ready);
	modport sink(input valid, file_byte, start_of_file, end_of_file, output ready);
endinterface

// Result channel
interface bmpdec_out_if;
	import bmpdec_pkg::*;

	logic        valid;
	logic        ready;
	kind_t       result_kind;
	err_t        error_code;
	logic [15:0] rgb565;
	logic [7:0]  alpha;
	logic [9:0]  pixel_x;
	logic [9:0]  pixel_y;
	logic [10:0] image_width;
	logic [10:0] image_height;
	logic        last_pixel;

	modport source(output valid, result_kind, error_code, rgb565, alpha, pixel_x, pixel_y,
		image_width, image_height, last_pixel, input ready);
	modport sink(input valid, result_kind, error_code, rgb565, alpha, pixel_x, pixel_y,
		image_width, image_height, last_pixel, output ready);
endinterface

FILE: rtl/bmpdec_in_reg.sv
module bmpdec_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	bmpdec_in_if.sink          byte_ch,
	input  logic               out_free,
	output logic               valid_s1,
	output bmpdec_pkg::item_t  item_s1
);
	import bmpdec_pkg::*;

	logic load;

	// The register empties whenever the result side can take the held byte
	assign byte_ch.ready = !valid_s1 || out_free;
	assign load = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	// Payload is captured only on an accepted request
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.file_byte     <= byte_ch.file_byte;
			item_s1.start_of_file <= byte_ch.start_of_file;
			item_s1.end_of_file   <= byte_ch.end_of_file;
		end
	end

endmodule

FILE: rtl/bmpdec_hdr.sv
module bmpdec_hdr #(
	parameter int MAX_DIM = bmpdec_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  bmpdec_pkg::cap_t                  cap,
	output bmpdec_pkg::hdr_chk_t              chk,
	output logic [$clog2(MAX_DIM + 1) - 1:0]  hdr_width,
	output logic [$clog2(MAX_DIM + 1) - 1:0]  hdr_height,
	output logic [31:0]                       data_offset
);
	import bmpdec_pkg::*;

	localparam int DW = $clog2(MAX_DIM + 1);

	logic [15:0] magic_q;
	logic [31:0] offset_q;
	logic [31:0] width_raw_q;
	logic [31:0] height_raw_q;
	logic [15:0] bpp_q;
	logic [31:0] comp_q;

	logic [5:0]  rel_magic, rel_data, rel_width, rel_height, rel_bpp, rel_comp;
	logic [31:0] abs_height;

	assign rel_magic  = cap.pos - 6'(HDR_OFS_MAGIC);
	assign rel_data   = cap.pos - 6'(HDR_OFS_DATA);
	assign rel_width  = cap.pos - 6'(HDR_OFS_WIDTH);
	assign rel_height = cap.pos - 6'(HDR_OFS_HEIGHT);
	assign rel_bpp    = cap.pos - 6'(HDR_OFS_BPP);
	assign rel_comp   = cap.pos - 6'(HDR_OFS_COMP);

	// Little-endian capture of the header fields; every field byte is written
	// before the check byte, so no clearing is needed on a new file.
	always_ff @(posedge clk) begin
		if (cap.en) begin
			if (cap.pos < 6'(HDR_OFS_MAGIC + 2)) begin
				magic_q[{rel_magic[0], 3'b000} +: 8] <= cap.data;
			end
			if (cap.pos >= 6'(HDR_OFS_DATA) && cap.pos < 6'(HDR_OFS_DATA + 4)) begin
				offset_q[{rel_data[1:0], 3'b000} +: 8] <= cap.data;
			end
			if (cap.pos >= 6'(HDR_OFS_WIDTH) && cap.pos < 6'(HDR_OFS_WIDTH + 4)) begin
				width_raw_q[{rel_width[1:0], 3'b000} +: 8] <= cap.data;
			end
			if (cap.pos >= 6'(HDR_OFS_HEIGHT) && cap.pos < 6'(HDR_OFS_HEIGHT + 4)) begin
				height_raw_q[{rel_height[1:0], 3'b000} +: 8] <= cap.data;
			end
			if (cap.pos >= 6'(HDR_OFS_BPP) && cap.pos < 6'(HDR_OFS_BPP + 2)) begin
				bpp_q[{rel_bpp[0], 3'b000} +: 8] <= cap.data;
			end
			if (cap.pos >= 6'(HDR_OFS_COMP) && cap.pos < 6'(HDR_OFS_COMP + 4)) begin
				comp_q[{rel_comp[1:0], 3'b000} +: 8] <= cap.data;
			end
		end
	end

	// A negative height marks a top-down image
	assign abs_height = height_raw_q[31] ? (~height_raw_q + 32'd1) : height_raw_q;

	// Checks in priority order; the first failure wins
	always_comb begin
		chk.bottom_up = !height_raw_q[31];
		if (magic_q != BMP_MAGIC) begin
			chk.err = ERR_MAGIC;
		end else if (bpp_q != BMP_BPP || comp_q != BMP_COMP_NONE) begin
			chk.err = ERR_FORMAT;
		end else if (width_raw_q == 32'd0 || width_raw_q > 32'(MAX_DIM)) begin
			chk.err = ERR_DIMS;
		end else if (abs_height == 32'd0 || abs_height > 32'(MAX_DIM)) begin
			chk.err = ERR_DIMS;
		end else if (offset_q < HDR_SIZE) begin
			chk.err = ERR_OFFSET;
		end else begin
			chk.err = ERR_NONE;
		end
	end

	assign hdr_width   = DW'(width_raw_q);
	assign hdr_height  = DW'(abs_height);
	assign data_offset = offset_q;

endmodule

FILE: rtl/bmpdec_parser.sv
module bmpdec_parser #(
	parameter int MAX_DIM = bmpdec_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  bmpdec_pkg::item_t                 item_s1,
	input  logic [7:0]                        key_min_red_blue,
	input  logic [7:0]                        key_max_green,
	input  bmpdec_pkg::hdr_chk_t              chk,
	input  logic [$clog2(MAX_DIM + 1) - 1:0]  hdr_width,
	input  logic [$clog2(MAX_DIM + 1) - 1:0]  hdr_height,
	input  logic [31:0]                       data_offset,
	output bmpdec_pkg::cap_t                  cap,
	output logic                              res_valid,
	output bmpdec_pkg::res_t                  res
);
	import bmpdec_pkg::*;

	localparam int DW = $clog2(MAX_DIM + 1);

	phase_t          phase_q, phase_eff, phase_nx, phase_d;
	logic [31:0]     pos_q, pos_eff, pos_d;
	logic [1:0]      bip_q, bip_eff, bip_d;
	logic [1:0]      pad_q, pad_d;
	logic [DW-1:0]   col_q, col_eff, col_d, col_inc;
	logic [DW-1:0]   row_q, row_eff, row_d, row_inc;
	logic [DW-1:0]   width_q, height_q, py;
	logic            bottom_up_q;
	logic [7:0]      blue_q, green_q;
	logic            hdr_done, pixel_done, trunc;
	logic            key_hit;

	// A start mark restarts the parser at file byte zero
	always_comb begin
		if (item_s1.start_of_file) begin
			phase_eff = PH_HEADER;
			pos_eff   = 32'd0;
			bip_eff   = 2'd0;
			col_eff   = '0;
			row_eff   = '0;
		end else begin
			phase_eff = phase_q;
			pos_eff   = pos_q;
			bip_eff   = bip_q;
			col_eff   = col_q;
			row_eff   = row_q;
		end
	end

	assign col_inc    = col_eff + 1'b1;
	assign row_inc    = row_eff + 1'b1;
	assign pos_d      = pos_eff + 32'd1;
	assign hdr_done   = (phase_eff == PH_HEADER) && (pos_eff[5:0] == HDR_LAST_POS);
	assign pixel_done = (phase_eff == PH_PIXEL) && (bip_eff != 2'd0) && (bip_eff != 2'd1);

	// Header bytes go to the capture registers
	assign cap.en   = take && (phase_eff == PH_HEADER);
	assign cap.pos  = pos_eff[5:0];
	assign cap.data = item_s1.file_byte;

	// Next state
	always_comb begin
		phase_nx = phase_eff;
		bip_d    = bip_eff;
		pad_d    = pad_q;
		col_d    = col_eff;
		row_d    = row_eff;
		case (phase_eff)
			PH_HEADER: begin
				if (hdr_done) begin
					if (chk.err != ERR_NONE) begin
						phase_nx = PH_ERROR;
					end else if (data_offset > HDR_SIZE) begin
						phase_nx = PH_SKIP;
					end else begin
						phase_nx = PH_PIXEL;
					end
				end
			end
			PH_SKIP: begin
				if (pos_d >= data_offset) begin
					phase_nx = PH_PIXEL;
				end
			end
			PH_PIXEL: begin
				case (bip_eff)
					2'd0: bip_d = 2'd1;
					2'd1: bip_d = 2'd2;
					default: begin
						bip_d = 2'd0;
						col_d = col_inc;
						if (col_inc >= width_q) begin
							pad_d = width_q[1:0];
							if (width_q[1:0] != 2'd0) begin
								phase_nx = PH_PAD;
							end else begin
								col_d    = '0;
								row_d    = row_inc;
								phase_nx = (row_inc >= height_q) ? PH_DONE : PH_PIXEL;
							end
						end
					end
				endcase
			end
			PH_PAD: begin
				pad_d = pad_q - 2'd1;
				if (pad_d == 2'd0) begin
					col_d    = '0;
					row_d    = row_inc;
					phase_nx = (row_inc >= height_q) ? PH_DONE : PH_PIXEL;
				end
			end
			default: begin
				phase_nx = phase_eff;
			end
		endcase
	end

	// An end mark before the image is complete turns into a truncation error
	assign trunc   = item_s1.end_of_file && (phase_nx != PH_DONE) && (phase_nx != PH_ERROR);
	assign phase_d = trunc ? PH_ERROR : phase_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 32'd0;
			bip_q   <= 2'd0;
			pad_q   <= 2'd0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			bip_q   <= bip_d;
			pad_q   <= pad_d;
			col_q   <= col_d;
			row_q   <= row_d;
		end
	end

	// Image geometry is latched when the header passes, colour bytes as they arrive
	always_ff @(posedge clk) begin
		if (take && hdr_done && chk.err == ERR_NONE) begin
			width_q     <= hdr_width;
			height_q    <= hdr_height;
			bottom_up_q <= chk.bottom_up;
		end
		if (take && phase_eff == PH_PIXEL && bip_eff == 2'd0) begin
			blue_q <= item_s1.file_byte;
		end
		if (take && phase_eff == PH_PIXEL && bip_eff == 2'd1) begin
			green_q <= item_s1.file_byte;
		end
	end

	// Pixel conversion helpers
	assign key_hit = (item_s1.file_byte >= key_min_red_blue) && (green_q <= key_max_green)
		&& (blue_q >= key_min_red_blue);
	assign py = bottom_up_q ? (height_q - 1'b1 - row_eff) : row_eff;

	// Result
	always_comb begin
		res       = '0;
		res.kind  = KIND_PIXEL;
		res.err   = ERR_NONE;
		res_valid = 1'b0;
		if (trunc) begin
			res_valid = 1'b1;
			res.kind  = KIND_ERROR;
			res.err   = ERR_TRUNC;
		end else if (hdr_done) begin
			res_valid = 1'b1;
			if (chk.err != ERR_NONE) begin
				res.kind = KIND_ERROR;
				res.err  = chk.err;
			end else begin
				res.kind         = KIND_HEADER;
				res.image_width  = 11'(hdr_width);
				res.image_height = 11'(hdr_height);
			end
		end else if (pixel_done) begin
			res_valid        = 1'b1;
			res.kind         = KIND_PIXEL;
			res.rgb565       = {item_s1.file_byte[7:3], green_q[7:2], blue_q[7:3]};
			res.alpha        = key_hit ? ALPHA_CLEAR : ALPHA_OPAQUE;
			res.pixel_x      = 10'(col_eff);
			res.pixel_y      = 10'(py);
			res.image_width  = 11'(width_q);
			res.image_height = 11'(height_q);
			res.last_pixel   = (row_inc == height_q) && (col_inc == width_q);
		end
	end

endmodule

FILE: rtl/bmpdec_out_reg.sv
module bmpdec_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              res_valid,
	input  bmpdec_pkg::res_t  res,
	output logic              out_free,
	bmpdec_out_if.source      result_ch
);
	import bmpdec_pkg::*;

	logic valid_s2;
	res_t res_s2;

	// The register may be refilled when empty or being drained this cycle
	assign out_free = !valid_s2 || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= take && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			res_s2 <= res;
		end
	end

	assign result_ch.valid        = valid_s2;
	assign result_ch.result_kind  = res_s2.kind;
	assign result_ch.error_code   = res_s2.err;
	assign result_ch.rgb565       = res_s2.rgb565;
	assign result_ch.alpha        = res_s2.alpha;
	assign result_ch.pixel_x      = res_s2.pixel_x;
	assign result_ch.pixel_y      = res_s2.pixel_y;
	assign result_ch.image_width  = res_s2.image_width;
	assign result_ch.image_height = res_s2.image_height;
	assign result_ch.last_pixel   = res_s2.last_pixel;

endmodule

FILE: rtl/bmp24_to_rgb565_alpha_decoder_top.sv
// Pipeline: the input register, then the result register after the parsing and
// conversion logic.
// Throughput: one file byte per cycle, as the parser updates on every byte it takes; the
// input stalls only while a waiting result is not taken.
// Reset: arst_n clears the parser to the start of a file and the chroma key
// registers to 248 (red and blue minimum) and 8 (green maximum).
module bmp24_to_rgb565_alpha_decoder_top #(
	parameter int MAX_DIM = bmpdec_pkg::MAX_DIM_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write_en,
	input  logic [0:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	bmpdec_in_if.sink     byte_ch,
	bmpdec_out_if.source  result_ch
);
	import bmpdec_pkg::*;

	localparam int DW = $clog2(MAX_DIM + 1);

	logic [7:0]    key_min_red_blue_q;
	logic [7:0]    key_max_green_q;
	logic          out_free, valid_s1, take, res_valid;
	item_t         item_s1;
	cap_t          cap;
	hdr_chk_t      chk;
	logic [DW-1:0] hdr_width, hdr_height;
	logic [31:0]   data_offset;
	res_t          res;

	// Chroma key configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_min_red_blue_q <= KEY_MIN_RB_RST;
			key_max_green_q    <= KEY_MAX_G_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_KEY_MIN_RB: key_min_red_blue_q <= cfg_data;
				CFG_KEY_MAX_G:  key_max_green_q    <= cfg_data;
				default: begin
					key_min_red_blue_q <= key_min_red_blue_q;
				end
			endcase
		end
	end

	// The held byte is processed once the result register has room
	assign take = valid_s1 && out_free;

	bmpdec_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.out_free (out_free),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bmpdec_hdr #(
		.MAX_DIM (MAX_DIM)
	) u_hdr (
		.clk         (clk),
		.cap         (cap),
		.chk         (chk),
		.hdr_width   (hdr_width),
		.hdr_height  (hdr_height),
		.data_offset (data_offset)
	);

	bmpdec_parser #(
		.MAX_DIM (MAX_DIM)
	) u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.item_s1          (item_s1),
		.key_min_red_blue (key_min_red_blue_q),
		.key_max_green    (key_max_green_q),
		.chk              (chk),
		.hdr_width        (hdr_width),
		.hdr_height       (hdr_height),
		.data_offset      (data_offset),
		.cap              (cap),
		.res_valid        (res_valid),
		.res              (res)
	);

	bmpdec_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.result_ch (result_ch)
	);

endmodule

FILE: sim/tb_bmp24_to_rgb565_alpha_decoder_top.sv
`timescale 1ns / 1ps

import bmpdec_pkg::*;

// Follows the parser byte by byte and holds the results the decoder owes us.
class bmp_scoreboard;
	bit [7:0]  key_min_rb;
	bit [7:0]  key_max_g;
	bit [31:0] file_pos;
	phase_t    phase;
	bit [15:0] magic;
	bit [31:0] data_ofs;
	bit [31:0] raw_w;
	bit [31:0] raw_h;
	bit [15:0] bpp;
	bit [31:0] comp;
	bit        bottom_up;
	bit [10:0] col_cnt;
	bit [10:0] row_cnt;
	bit [1:0]  byte_in_px;
	bit [1:0]  pad_left;
	bit [7:0]  blue;
	bit [7:0]  green;
	res_t      decoded_q[$];
	int        errors;

	function new();
		key_min_rb = KEY_MIN_RB_RST;
		key_max_g = KEY_MAX_G_RST;
		errors = 0;
		restart();
	endfunction

	function void set_key(cfg_idx_t idx, bit [7:0] val);
		if (idx == CFG_KEY_MIN_RB) key_min_rb = val;
		else key_max_g = val;
	endfunction

	function int pending();
		return decoded_q.size();
	endfunction

	function void restart();
		file_pos = 0;
		phase = PH_HEADER;
		magic = 0;
		data_ofs = 0;
		raw_w = 0;
		raw_h = 0;
		bpp = 0;
		comp = 0;
		bottom_up = 0;
		col_cnt = 0;
		row_cnt = 0;
		byte_in_px = 0;
		pad_left = 0;
		blue = 0;
		green = 0;
	endfunction

	function bit [31:0] abs_height();
		return raw_h[31] ? (~raw_h + 32'd1) : raw_h;
	endfunction

	// Header fields are little-endian, so each byte lands at its lane.
	function void capture(bit [31:0] pos, bit [7:0] b);
		if (pos < HDR_OFS_MAGIC + 2) magic[8*pos +: 8] = b;
		else if (pos >= HDR_OFS_DATA && pos < HDR_OFS_DATA + 4)
			data_ofs[8*(pos - HDR_OFS_DATA) +: 8] = b;
		else if (pos >= HDR_OFS_WIDTH && pos < HDR_OFS_WIDTH + 4)
			raw_w[8*(pos - HDR_OFS_WIDTH) +: 8] = b;
		else if (pos >= HDR_OFS_HEIGHT && pos < HDR_OFS_HEIGHT + 4)
			raw_h[8*(pos - HDR_OFS_HEIGHT) +: 8] = b;
		else if (pos >= HDR_OFS_BPP && pos < HDR_OFS_BPP + 2)
			bpp[8*(pos - HDR_OFS_BPP) +: 8] = b;
		else if (pos >= HDR_OFS_COMP && pos < HDR_OFS_COMP + 4)
			comp[8*(pos - HDR_OFS_COMP) +: 8] = b;
	endfunction

	// The first failing check in the order magic, format, size, offset wins.
	function err_t header_check();
		bit [31:0] h;
		h = abs_height();
		if (magic != BMP_MAGIC) return ERR_MAGIC;
		if (bpp != BMP_BPP || comp != BMP_COMP_NONE) return ERR_FORMAT;
		if (raw_w == 0 || raw_w > MAX_DIM_DEF) return ERR_DIMS;
		if (h == 0 || h > MAX_DIM_DEF) return ERR_DIMS;
		if (data_ofs < HDR_SIZE) return ERR_OFFSET;
		return ERR_NONE;
	endfunction

	function void finish_row();
		col_cnt = 0;
		row_cnt++;
		phase = (row_cnt >= abs_height()) ? PH_DONE : PH_PIXEL;
	endfunction

	// Advances the parser by one accepted request and queues any result it owes.
	function void note_byte(bit [7:0] b, bit sof, bit eof);
		res_t      r;
		bit        emit;
		bit [31:0] pos;
		bit [31:0] hh;
		bit [31:0] row_dst;
		err_t      e;
		r = '0;
		emit = 0;
		if (sof) restart();
		pos = file_pos;
		file_pos = pos + 32'd1;
		case (phase)
		PH_HEADER: begin
			capture(pos, b);
			if (pos == HDR_LAST_POS) begin
				e = header_check();
				emit = 1;
				if (e != ERR_NONE) begin
					r.kind = KIND_ERROR;
					r.err = e;
					phase = PH_ERROR;
				end else begin
					hh = abs_height();
					r.kind = KIND_HEADER;
					r.image_width = raw_w[10:0];
					r.image_height = hh[10:0];
					bottom_up = !raw_h[31];
					phase = (data_ofs > HDR_SIZE) ? PH_SKIP : PH_PIXEL;
				end
			end
		end
		PH_SKIP: begin
			if (pos + 32'd1 >= data_ofs) phase = PH_PIXEL;
		end
		PH_PIXEL: begin
			if (byte_in_px == 0) begin
				blue = b;
				byte_in_px = 1;
			end else if (byte_in_px == 1) begin
				green = b;
				byte_in_px = 2;
			end else begin
				// Red completes the triple; bottom-up rows are mirrored vertically.
				hh = abs_height();
				byte_in_px = 0;
				emit = 1;
				row_dst = bottom_up ? (hh - 32'd1 - row_cnt) : 32'(row_cnt);
				r.kind = KIND_PIXEL;
				r.rgb565 = {b[7:3], green[7:2], blue[7:3]};
				r.alpha = (b >= key_min_rb && green <= key_max_g && blue >= key_min_rb) ?
					ALPHA_CLEAR : ALPHA_OPAQUE;
				r.pixel_x = col_cnt[9:0];
				r.pixel_y = row_dst[9:0];
				r.image_width = raw_w[10:0];
				r.image_height = hh[10:0];
				r.last_pixel = (row_cnt + 32'd1 == hh) && (col_cnt + 32'd1 == raw_w);
				col_cnt++;
				if (col_cnt >= raw_w) begin
					pad_left = raw_w[1:0];
					if (pad_left != 0) phase = PH_PAD;
					else finish_row();
				end
			end
		end
		PH_PAD: begin
			pad_left = pad_left - 2'd1;
			if (pad_left == 0) finish_row();
		end
		default: ;
		endcase

		// An early end of file replaces whatever this byte would have produced.
		if (eof && phase != PH_DONE && phase != PH_ERROR) begin
			phase = PH_ERROR;
			emit = 1;
			r = '0;
			r.kind = KIND_ERROR;
			r.err = ERR_TRUNC;
		end
		if (emit) decoded_q.push_back(r);
	endfunction

	function string describe(res_t r);
		return $sformatf("kind %0d err %0d rgb %h alpha %h x %0d y %0d w %0d h %0d last %0d",
			r.kind, r.err, r.rgb565, r.alpha, r.pixel_x, r.pixel_y, r.image_width,
			r.image_height, r.last_pixel);
	endfunction

	function void check_result(res_t got);
		res_t want;
		if (decoded_q.size() == 0) begin
			errors++;
			$display("%0t: result with none awaited: %s", $time, describe(got));
			return;
		end
		want = decoded_q.pop_front();
		if (got !== want) begin
			errors++;
			$display("%0t: result mismatch, expected %s", $time, describe(want));
			$display("%0t:                   actual   %s", $time, describe(got));
		end
	endfunction
endclass

module tb_bmp24_to_rgb565_alpha_decoder_top;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD = 200;
	localparam int PHASE_BYTES = 60;
	localparam int WHOLE = 0;

	logic       clk;
	logic       arst_n;
	logic       cfg_write_en;
	logic [0:0] cfg_index;
	logic [7:0] cfg_data;

	bmpdec_in_if  byte_ch();
	bmpdec_out_if result_ch();

	bmp_scoreboard sb = new();
	bit [7:0]      bmp_q[$];
	bit            calm;
	bit            hold_request;
	int            cycle_count;
	res_t          seen;

	bmp24_to_rgb565_alpha_decoder_top #(
		.MAX_DIM(MAX_DIM_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_ch(byte_ch),
		.result_ch(result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_bmp24_to_rgb565_alpha_decoder_top: done, errors");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off when asked for.
	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Both channels are observed at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready)
				sb.note_byte(byte_ch.file_byte, byte_ch.start_of_file, byte_ch.end_of_file);
			if (result_ch.valid && result_ch.ready) begin
				seen.kind = result_ch.result_kind;
				seen.err = result_ch.error_code;
				seen.rgb565 = result_ch.rgb565;
				seen.alpha = result_ch.alpha;
				seen.pixel_x = result_ch.pixel_x;
				seen.pixel_y = result_ch.pixel_y;
				seen.image_width = result_ch.image_width;
				seen.image_height = result_ch.image_height;
				seen.last_pixel = result_ch.last_pixel;
				sb.check_result(seen);
			end
		end
	end

	// Pixel channels lean towards the chroma key edges.
	function bit [7:0] pixel_channel();
		case ($urandom_range(0, 5))
		0: return 8'hFF;
		1: return 8'h00;
		2: return sb.key_min_rb;
		3: return sb.key_max_g;
		4: return sb.key_min_rb - 8'd1;
		default: return 8'($urandom);
		endcase
	endfunction

	// Lays out a file in bmp_q; pixel data follows only a header that will pass.
	function void build_bmp(bit [15:0] magic, bit [31:0] ofs, bit [31:0] w, bit [31:0] h,
			bit [15:0] bpp, bit [31:0] comp);
		bit [31:0] rows;
		bit        decodable;
		rows = h[31] ? (~h + 32'd1) : h;
		decodable = magic == BMP_MAGIC && bpp == BMP_BPP && comp == BMP_COMP_NONE &&
			w >= 1 && w <= MAX_DIM_DEF && rows >= 1 && rows <= MAX_DIM_DEF &&
			ofs >= HDR_SIZE && ofs <= HDR_SIZE + 32;
		bmp_q.delete();
		repeat (HDR_SIZE) bmp_q.push_back(8'($urandom));
		for (int i = 0; i < 4; i++) begin
			if (i < 2) begin
				bmp_q[HDR_OFS_MAGIC + i] = magic[8*i +: 8];
				bmp_q[HDR_OFS_BPP + i] = bpp[8*i +: 8];
			end
			bmp_q[HDR_OFS_DATA + i] = ofs[8*i +: 8];
			bmp_q[HDR_OFS_WIDTH + i] = w[8*i +: 8];
			bmp_q[HDR_OFS_HEIGHT + i] = h[8*i +: 8];
			bmp_q[HDR_OFS_COMP + i] = comp[8*i +: 8];
		end
		if (decodable) begin
			repeat (ofs - HDR_SIZE) bmp_q.push_back(8'($urandom));
			repeat (rows) begin
				repeat (w) repeat (3) bmp_q.push_back(pixel_channel());
				repeat (w[1:0]) bmp_q.push_back(8'($urandom));
			end
		end else begin
			repeat (8) bmp_q.push_back(8'($urandom));
		end
	endfunction

	// Offers one request, with an occasional gap in front of it.
	task automatic send_byte(bit [7:0] b, bit sof, bit eof);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.file_byte <= b;
		byte_ch.start_of_file <= sof;
		byte_ch.end_of_file <= eof;
		do @(posedge clk); while (!byte_ch.ready);
	endtask

	task automatic send_bmp(int count, bit use_sof, bit mark_eof);
		for (int i = 0; i < count; i++)
			send_byte(bmp_q[i], use_sof && i == 0, mark_eof && i == count - 1);
	endtask

	task automatic run_bmp(bit [15:0] magic, bit [31:0] ofs, bit [31:0] w, bit [31:0] h,
			bit [15:0] bpp, bit [31:0] comp, int cut, bit use_sof, bit mark_eof);
		build_bmp(magic, ofs, w, h, bpp, comp);
		send_bmp((cut == WHOLE) ? bmp_q.size() : cut, use_sof, mark_eof);
	endtask

	task automatic send_noise(int n);
		repeat (n)
			send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
	endtask

	// Lets the decoder drain before the keys are touched or the run ends.
	task automatic settle();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_key(cfg_idx_t idx, bit [7:0] val);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		sb.set_key(idx, val);
	endtask

	// Mostly small well-formed images; some broken headers, cut-off files and noise.
	task automatic random_bmp(output int sent);
		bit [15:0] magic;
		bit [15:0] bpp;
		bit [31:0] ofs;
		bit [31:0] w;
		bit [31:0] h;
		bit [31:0] comp;
		int        pick;
		int        len;
		int        cut;
		magic = BMP_MAGIC;
		bpp = BMP_BPP;
		comp = BMP_COMP_NONE;
		w = $urandom_range(1, 9);
		h = $urandom_range(1, 6);
		if ($urandom_range(0, 1) == 1) h = -h;
		ofs = HDR_SIZE + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			case ($urandom_range(0, 5))
			0: magic = magic ^ (16'd1 << $urandom_range(0, 15));
			1: bpp = 16'($urandom);
			2: comp = $urandom_range(1, 3);
			3: w = ($urandom_range(0, 1) == 1) ? 32'd0 : 32'($urandom);
			4: h = ($urandom_range(0, 1) == 1) ? 32'd0 : -32'($urandom_range(1025, 4096));
			default: ofs = $urandom_range(0, 53);
			endcase
		end
		build_bmp(magic, ofs, w, h, bpp, comp);
		len = bmp_q.size();
		if (pick >= 10 && pick < 22) begin
			cut = $urandom_range(1, len - 1);
			send_bmp(cut, 1'b1, pick < 18);
			sent = cut;
		end else begin
			send_bmp(len, 1'b1, $urandom_range(0, 4) != 0);
			sent = len;
			if (pick >= 90) send_noise($urandom_range(1, 6));
		end
	endtask

	task automatic random_phase();
		int total;
		int sent;
		total = 0;
		while (total < PHASE_BYTES) begin
			random_bmp(sent);
			total += sent;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = CFG_KEY_MIN_RB;
		cfg_data = 8'd0;
		byte_ch.valid = 1'b0;
		byte_ch.file_byte = 8'd0;
		byte_ch.start_of_file = 1'b0;
		byte_ch.end_of_file = 1'b0;
		calm = 0;
		hold_request = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed files under the reset keys; the first carries no start mark.
		run_bmp(BMP_MAGIC, HDR_SIZE, 2, 2, BMP_BPP, BMP_COMP_NONE, WHOLE, 0, 1);
		run_bmp(16'h4D43, HDR_SIZE, 2, 2, 16'd32, BMP_COMP_NONE, WHOLE, 1, 1);
		run_bmp(16'h424D, HDR_SIZE, 2, 2, BMP_BPP, BMP_COMP_NONE, WHOLE, 1, 1);
		run_bmp(BMP_MAGIC, HDR_SIZE, 2, 2, 16'd32, BMP_COMP_NONE, WHOLE, 1, 1);
		run_bmp(BMP_MAGIC, HDR_SIZE, 2, 2, BMP_BPP, 32'd1, WHOLE, 1, 1);
		run_bmp(BMP_MAGIC, HDR_SIZE, 0, 2, BMP_BPP, BMP_COMP_NONE, WHOLE, 1, 1);
		run_bmp(BMP_MAGIC, HDR_SIZE, 1025, 2, BMP_BPP, BMP_COMP_NONE, WHOLE, 1, 1);
		run_bmp(BMP_MAGIC, HDR_SIZE, 2, 0, BMP_BPP, BMP_COMP_NONE, WHOLE, 1, 1);
		run_bmp(BMP_MAGIC, HDR_SIZE, 2, -32'sd1025, BMP_BPP, BMP_COMP_NONE, WHOLE, 1, 1);
		run_bmp(BMP_MAGIC, HDR_SIZE, 2, 32'h8000_0000, BMP_BPP, BMP_COMP_NONE, WHOLE, 1, 1);
		run_bmp(BMP_MAGIC, 32'd53, 2, 2, BMP_BPP, BMP_COMP_NONE, WHOLE, 1, 1);
		run_bmp(BMP_MAGIC, 32'd0, 2, 2, BMP_BPP, BMP_COMP_NONE, WHOLE, 1, 1);
		// End of file on the last header byte: a header error still takes precedence.
		run_bmp(16'h0000, HDR_SIZE, 2, 2, BMP_BPP, BMP_COMP_NONE, 54, 1, 1);
		run_bmp(BMP_MAGIC, HDR_SIZE, 2, 2, BMP_BPP, BMP_COMP_NONE, 54, 1, 1);
		// Files cut short: one byte, mid-header, mid-pixel and inside row padding.
		run_bmp(BMP_MAGIC, HDR_SIZE, 2, 2, BMP_BPP, BMP_COMP_NONE, 1, 1, 1);
		run_bmp(BMP_MAGIC, HDR_SIZE, 2, 2, BMP_BPP, BMP_COMP_NONE, 30, 1, 1);
		run_bmp(BMP_MAGIC, HDR_SIZE, 3, 2, BMP_BPP, BMP_COMP_NONE, 73, 1, 1);
		run_bmp(BMP_MAGIC, HDR_SIZE, 2, 1, BMP_BPP, BMP_COMP_NONE, 61, 1, 1);
		// Top-down image behind skipped bytes, then trailing bytes that must be ignored.
		run_bmp(BMP_MAGIC, 32'd58, 3, -32'sd2, BMP_BPP, BMP_COMP_NONE, WHOLE, 1, 1);
		for (int i = 0; i < 5; i++) send_byte(8'($urandom), 1'b0, i == 4);
		// A new start mark in the middle of a file restarts the parser.
		run_bmp(BMP_MAGIC, HDR_SIZE, 5, 3, BMP_BPP, BMP_COMP_NONE, 70, 1, 0);
		run_bmp(BMP_MAGIC, HDR_SIZE, 4, 1, BMP_BPP, BMP_COMP_NONE, WHOLE, 1, 0);
		// Largest width and largest bottom-up height, cut short after the first pixels.
		run_bmp(BMP_MAGIC, HDR_SIZE, 1024, 1, BMP_BPP, BMP_COMP_NONE, 63, 1, 1);
		run_bmp(BMP_MAGIC, HDR_SIZE, 1, 32'd1024, BMP_BPP, BMP_COMP_NONE, 66, 1, 1);

		// Random files over several key settings, extremes first.
		settle();
		write_key(CFG_KEY_MIN_RB, 8'hFF);
		write_key(CFG_KEY_MAX_G, 8'h00);
		hold_request = 1;
		random_phase();

		settle();
		write_key(CFG_KEY_MIN_RB, 8'h00);
		write_key(CFG_KEY_MAX_G, 8'hFF);
		random_phase();

		settle();
		write_key(CFG_KEY_MIN_RB, 8'($urandom));
		write_key(CFG_KEY_MAX_G, 8'($urandom));
		random_phase();

		// Last stretch runs without any idling on either side.
		settle();
		write_key(CFG_KEY_MIN_RB, KEY_MIN_RB_RST);
		write_key(CFG_KEY_MAX_G, KEY_MAX_G_RST);
		calm = 1;
		random_phase();

		settle();
		if (sb.errors == 0) begin
			$display("tb_bmp24_to_rgb565_alpha_decoder_top: done, clean");
		end else begin
			$display("tb_bmp24_to_rgb565_alpha_decoder_top: done, errors");
		end
		$finish;
	end
endmodule

FILE: files.f
rtl/bmpdec_pkg.sv
rtl/bmpdec_if.sv
rtl/bmpdec_in_reg.sv
rtl/bmpdec_hdr.sv
rtl/bmpdec_parser.sv
rtl/bmpdec_out_reg.sv
rtl/bmp24_to_rgb565_alpha_decoder_top.sv
sim/tb_bmp24_to_rgb565_alpha_decoder_top.sv
